/* rtl/tcpq_pkg.sv */
`default_nettype none

package tcpq_pkg;

	// table size and field widths
	localparam int MAX_NODES  = 1024;
	localparam int NODE_W     = 10;
	localparam int ADDR_W     = $clog2(MAX_NODES);
	localparam int CHAIN_HOPS = 20;
	localparam int HOP_W      = $clog2(CHAIN_HOPS + 1);

	typedef logic [NODE_W-1:0] node_t;

	// request opcodes
	typedef enum logic [1:0] {
		ACT_LOAD    = 2'd0,
		ACT_LCA     = 2'd1,
		ACT_PATH    = 2'd2,
		ACT_SUBTREE = 2'd3
	} action_t;

	// one node entry as stored in the table
	typedef struct packed {
		node_t pos;
		node_t sub_end;
		node_t head;
		node_t hop;
	} entry_t;

	// one result item
	typedef struct packed {
		node_t result_node;
		node_t seg_low;
		node_t seg_high;
		logic  empty_path;
		logic  last;
	} result_t;

endpackage

`default_nettype wire

/* rtl/tcpq_req_if.sv */
`default_nettype none

interface tcpq_req_if
	import tcpq_pkg::*;
;
	logic    valid;
	logic    ready;
	action_t action;
	node_t   node_a;
	node_t   node_b;
	logic    skip_top;
	node_t   entry_pos;
	node_t   entry_end;
	node_t   entry_head;
	node_t   entry_hop;

	modport source (
		output valid, action, node_a, node_b, skip_top,
		output entry_pos, entry_end, entry_head, entry_hop,
		input  ready
	);

	modport sink (
		input  valid, action, node_a, node_b, skip_top,
		input  entry_pos, entry_end, entry_head, entry_hop,
		output ready
	);
endinterface

`default_nettype wire

/* rtl/tcpq_rsp_if.sv */
`default_nettype none

interface tcpq_rsp_if
	import tcpq_pkg::*;
;
	logic  valid;
	logic  ready;
	node_t result_node;
	node_t seg_low;
	node_t seg_high;
	logic  empty_path;
	logic  last;

	modport source (
		output valid, result_node, seg_low, seg_high, empty_path, last,
		input  ready
	);

	modport sink (
		input  valid, result_node, seg_low, seg_high, empty_path, last,
		output ready
	);
endinterface

`default_nettype wire

/* rtl/tree_chain_path_query.sv */
// Heavy-light decomposition query engine.
// req channel (valid/ready) takes one item at a time: a load writes one node's
// entry (position, subtree end, chain head, parent of head) in the transfer
// cycle and returns nothing; a subtree query returns one result with the
// node's position interval; an lca query returns one result with the meeting
// node; a path query returns one interval per chain climbed, meeting chain
// last, the final result flagged last, or a single result flagged empty_path.
// Node entries sit in one single-port table with a registered read, so
// every lookup waits on that read register. The climb of lca and path
// queries is capped at 20 hops. Path intervals are held back one hop so
// the last flag can land on the right item.
// rsp channel is driven from an output register; the next request is taken
// while the final result still waits there. A stalled receiver holds the
// engine only when it needs to place another result.
// Reset clears the control state and the output register; table entries are
// undefined until loaded and need no clearing.
`default_nettype none

module tree_chain_path_query
	import tcpq_pkg::*;
(
	input  wire logic   clk,
	input  wire logic   arst_n,
	tcpq_req_if.sink    req,
	tcpq_rsp_if.source  rsp
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_A,
		S_AH,
		S_B,
		S_BH,
		S_CHECK,
		S_DONE
	} state_t;

	// one side of the climb: node, its entry and the position of its head
	typedef struct packed {
		node_t node;
		node_t pos;
		node_t sub_end;
		node_t head;
		node_t hop;
		node_t hpos;
	} side_t;

	function automatic logic node_ok(node_t n);
		return 32'(n) < MAX_NODES;
	endfunction

	state_t            state_q;
	action_t           act_q;
	logic              skip_q;
	logic              climb_q;
	logic [HOP_W-1:0]  hops_q;
	side_t             a_q;
	side_t             b_q;
	logic              pend_vld_q;
	node_t             pend_lo_q;
	node_t             pend_hi_q;
	logic              out_vld_q;
	result_t           out_q;

	entry_t            mem_q [MAX_NODES];
	entry_t            rdata_q;
	logic              rd_ok_q;
	entry_t            rd_c;
	node_t             addr_c;
	logic              mem_we;
	logic              req_xfer;
	logic              out_free;
	logic              out_set;

	side_t             lift_c;
	side_t             keep_c;
	logic              meet_c;
	logic              check_go;
	side_t             fa_c;
	side_t             fb_c;
	logic [NODE_W:0]   top_c;
	logic [NODE_W:0]   lo_c;
	logic              span_c;

	assign req.ready = (state_q == S_IDLE);
	assign req_xfer  = req.valid && req.ready;
	assign out_free  = !out_vld_q || rsp.ready;

	// out-of-range nodes read as zero
	assign rd_c = rd_ok_q ? rdata_q : '0;

	// climb decisions
	assign lift_c   = (a_q.hpos < b_q.hpos) ? b_q : a_q;
	assign keep_c   = (a_q.hpos < b_q.hpos) ? a_q : b_q;
	assign meet_c   = (hops_q == HOP_W'(CHAIN_HOPS)) || (a_q.head == b_q.head);
	assign check_go = !(act_q == ACT_PATH && pend_vld_q && !out_free);

	// output register is loaded on a held interval or a final answer
	assign out_set = (state_q == S_DONE && out_free) ||
		(state_q == S_CHECK && !meet_c && check_go && act_q == ACT_PATH && pend_vld_q);

	// final ordering and meeting chain interval
	assign fa_c   = (a_q.pos < b_q.pos) ? b_q : a_q;
	assign fb_c   = (a_q.pos < b_q.pos) ? a_q : b_q;
	assign top_c  = {1'b0, fb_c.pos} + (NODE_W+1)'(skip_q);
	assign lo_c   = (top_c > {1'b0, fa_c.hpos}) ? top_c : {1'b0, fa_c.hpos};
	assign span_c = lo_c <= {1'b0, fa_c.pos};

	// table address select
	always_comb begin
		case (state_q)
			S_IDLE:  addr_c = req.node_a;
			S_A:     addr_c = rd_c.head;
			S_AH:    addr_c = b_q.node;
			S_B:     addr_c = rd_c.head;
			S_CHECK: addr_c = lift_c.hop;
			default: addr_c = a_q.node;
		endcase
	end

	assign mem_we = req_xfer && (req.action == ACT_LOAD) && node_ok(req.node_a);

	// node table
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[ADDR_W'(addr_c)] <= '{pos: req.entry_pos, sub_end: req.entry_end,
				head: req.entry_head, hop: req.entry_hop};
		end
		rdata_q <= mem_q[ADDR_W'(addr_c)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_ok_q <= 1'b0;
		end else begin
			rd_ok_q <= node_ok(addr_c);
		end
	end

	// sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			act_q      <= ACT_LOAD;
			skip_q     <= 1'b0;
			climb_q    <= 1'b0;
			hops_q     <= '0;
			a_q        <= '0;
			b_q        <= '0;
			pend_vld_q <= 1'b0;
			pend_lo_q  <= '0;
			pend_hi_q  <= '0;
			out_vld_q  <= 1'b0;
			out_q      <= '0;
		end else begin
			out_vld_q <= out_set || (out_vld_q && !rsp.ready);
			case (state_q)
				S_IDLE: begin
					if (req_xfer && req.action != ACT_LOAD) begin
						act_q      <= req.action;
						skip_q     <= req.skip_top;
						climb_q    <= 1'b0;
						hops_q     <= '0;
						pend_vld_q <= 1'b0;
						a_q.node   <= req.node_a;
						b_q.node   <= req.node_b;
						state_q    <= S_A;
					end
				end
				S_A: begin
					a_q.pos     <= rd_c.pos;
					a_q.sub_end <= rd_c.sub_end;
					a_q.head    <= rd_c.head;
					a_q.hop     <= rd_c.hop;
					state_q     <= (act_q == ACT_SUBTREE) ? S_DONE : S_AH;
				end
				S_AH: begin
					a_q.hpos <= rd_c.pos;
					state_q  <= climb_q ? S_CHECK : S_B;
				end
				S_B: begin
					b_q.pos     <= rd_c.pos;
					b_q.sub_end <= rd_c.sub_end;
					b_q.head    <= rd_c.head;
					b_q.hop     <= rd_c.hop;
					state_q     <= S_BH;
				end
				S_BH: begin
					b_q.hpos <= rd_c.pos;
					climb_q  <= 1'b1;
					state_q  <= S_CHECK;
				end
				S_CHECK: begin
					if (meet_c) begin
						state_q <= S_DONE;
					end else if (check_go) begin
						// lift the deeper chain to the parent of its head
						b_q    <= keep_c;
						a_q    <= '{node: lift_c.hop, pos: lift_c.pos, sub_end: lift_c.sub_end,
							head: lift_c.head, hop: lift_c.hop, hpos: lift_c.hpos};
						hops_q <= hops_q + HOP_W'(1);
						if (act_q == ACT_PATH) begin
							if (pend_vld_q) begin
								out_q <= '{result_node: '0, seg_low: pend_lo_q,
									seg_high: pend_hi_q, empty_path: 1'b0, last: 1'b0};
							end
							pend_vld_q <= 1'b1;
							pend_lo_q  <= lift_c.hpos;
							pend_hi_q  <= lift_c.pos;
						end
						state_q <= S_A;
					end
				end
				S_DONE: begin
					if (out_free) begin
						case (act_q)
							ACT_SUBTREE: begin
								out_q   <= '{result_node: '0, seg_low: a_q.pos,
									seg_high: a_q.sub_end, empty_path: 1'b0, last: 1'b1};
								state_q <= S_IDLE;
							end
							ACT_LCA: begin
								out_q   <= '{result_node: fb_c.node, seg_low: '0,
									seg_high: '0, empty_path: 1'b0, last: 1'b1};
								state_q <= S_IDLE;
							end
							default: begin
								if (pend_vld_q && span_c) begin
									// flush the held chain interval first
									out_q      <= '{result_node: '0, seg_low: pend_lo_q,
										seg_high: pend_hi_q, empty_path: 1'b0, last: 1'b0};
									pend_vld_q <= 1'b0;
								end else if (span_c) begin
									out_q   <= '{result_node: '0, seg_low: lo_c[NODE_W-1:0],
										seg_high: fa_c.pos, empty_path: 1'b0, last: 1'b1};
									state_q <= S_IDLE;
								end else if (pend_vld_q) begin
									out_q      <= '{result_node: '0, seg_low: pend_lo_q,
										seg_high: pend_hi_q, empty_path: 1'b0, last: 1'b1};
									pend_vld_q <= 1'b0;
									state_q    <= S_IDLE;
								end else begin
									out_q   <= '{result_node: '0, seg_low: '0,
										seg_high: '0, empty_path: 1'b1, last: 1'b1};
									state_q <= S_IDLE;
								end
							end
						endcase
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid       = out_vld_q;
	assign rsp.result_node = out_q.result_node;
	assign rsp.seg_low     = out_q.seg_low;
	assign rsp.seg_high    = out_q.seg_high;
	assign rsp.empty_path  = out_q.empty_path;
	assign rsp.last        = out_q.last;

`ifndef NO_ASSERTIONS
	a_hops_bound: assert property (@(posedge clk) disable iff (!arst_n)
		hops_q <= HOP_W'(CHAIN_HOPS))
		else $error("hop counter beyond limit");

	a_hop_limit_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHECK && hops_q == HOP_W'(CHAIN_HOPS)) |=> state_q == S_DONE)
		else $error("climb did not stop at hop limit");

	a_pend_path_only: assert property (@(posedge clk) disable iff (!arst_n)
		pend_vld_q |-> act_q == ACT_PATH)
		else $error("held interval outside a path query");

	a_load_no_work: assert property (@(posedge clk) disable iff (!arst_n)
		(req_xfer && req.action == ACT_LOAD) |=> state_q == S_IDLE)
		else $error("load started a query");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_vld_q && !rsp.ready) |=> out_vld_q && $stable(out_q))
		else $error("pending result overwritten");
`endif

endmodule

`default_nettype wire
